### rtl/core/jse_pkg.sv
// Shared types and constants for the 3x3 symmetric Jacobi eigen core.
package jse_pkg;

    // Default datapath width and reset value of the rotation limit
    localparam int VALUE_WIDTH_DEF = 32;
    localparam logic [7:0] MAX_ROT_RESET = 8'd64;

    // Operation codes of the shared iterative unit
    localparam logic IU_SQRT = 1'b0;
    localparam logic IU_DIV  = 1'b1;

    // Request to the iterative unit
    typedef struct packed {
        logic start;
        logic mode;
    } t_iu_ctl;

    // Status from the iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_iu_sts;

endpackage

### rtl/core/jacobi_symmetric_eigen_3x3_core.sv
// Top level of the 3x3 symmetric eigen core using Jacobi rotations.
//
// Usage: an item is the upper triangle a00 a01 a02 a11 a12 a22 in Q16.16,
// taken when i_in_valid is high and o_in_stall is low. The core then runs
// Jacobi rotations on the largest off-diagonal entry and returns three items,
// one per eigenpair: eigenvalue (Q16.16), eigenvector (Q2.30), pair_index,
// last_pair and limit_reached. o_in_stall stays high from acceptance until
// the third result item has been taken.
// Each rotation uses the shared iterative unit for two square roots and
// three divisions, plus 20 steps on the one shared multiplier, the pivot
// search and the diagonal update. The first result follows the last
// rotation, at most max_rotations rotations after acceptance.
// Results are held while i_out_stall is high and advance one per cycle
// otherwise. The max_rotations register (reset 64) is written through the
// i_cfg_valid/o_cfg_ready channel, which is always ready.
// Reset (synchronous, i_rst_n low) returns the core to idle at once.
module jacobi_symmetric_eigen_3x3_core #(
    parameter int VALUE_WIDTH = jse_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_a00,
    input  logic signed [31:0] i_a01,
    input  logic signed [31:0] i_a02,
    input  logic signed [31:0] i_a11,
    input  logic signed [31:0] i_a12,
    input  logic signed [31:0] i_a22,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_eigen_value,
    output logic signed [31:0] o_vec_x,
    output logic signed [31:0] o_vec_y,
    output logic signed [31:0] o_vec_z,
    output logic [1:0]         o_pair_index,
    output logic               o_last_pair,
    output logic               o_limit_reached,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);
    import jse_pkg::*;

    localparam int VW_EFF = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_PICK  = 5'd1;
    localparam logic [4:0] ST_M1    = 5'd2;
    localparam logic [4:0] ST_M2    = 5'd3;
    localparam logic [4:0] ST_SQ1S  = 5'd4;
    localparam logic [4:0] ST_SQ1W  = 5'd5;
    localparam logic [4:0] ST_M3    = 5'd6;
    localparam logic [4:0] ST_M4    = 5'd7;
    localparam logic [4:0] ST_SQ2S  = 5'd8;
    localparam logic [4:0] ST_SQ2W  = 5'd9;
    localparam logic [4:0] ST_DV1S  = 5'd10;
    localparam logic [4:0] ST_DV1W  = 5'd11;
    localparam logic [4:0] ST_DV2S  = 5'd12;
    localparam logic [4:0] ST_DV2W  = 5'd13;
    localparam logic [4:0] ST_DV3S  = 5'd14;
    localparam logic [4:0] ST_DV3W  = 5'd15;
    localparam logic [4:0] ST_DIAG  = 5'd16;
    localparam logic [4:0] ST_ROT   = 5'd17;
    localparam logic [4:0] ST_OUT   = 5'd18;

    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

    // Saturate to a signed value of the given bit count
    function automatic logic signed [31:0] sat_to(input logic signed [35:0] x,
                                                  input int bits);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = (36'sd1 <<< (bits - 1)) - 36'sd1;
        lo = -hi - 36'sd1;
        if (x > hi) return hi[31:0];
        else if (x < lo) return lo[31:0];
        else return x[31:0];
    endfunction

    // Round half up at bit 30
    function automatic logic signed [35:0] rnd30(input logic signed [64:0] v);
        logic signed [64:0] t;
        t = v + 65'sd536870912;
        return 36'(t >>> 30);
    endfunction

    logic [4:0]         r_state;
    logic [7:0]         r_max;
    logic signed [31:0] r_diag [3];
    logic signed [31:0] r_off  [3];
    logic signed [31:0] r_vec  [9];
    logic [2:0]         r_chg;
    logic [1:0]         r_tie;
    logic [7:0]         r_cnt;
    logic               r_lim;
    logic [1:0]         r_oidx;
    logic [1:0]         r_q;
    logic signed [31:0] r_p;
    logic [31:0]        r_pa;
    logic [31:0]        r_ay;
    logic               r_neg;
    logic [63:0]        r_pp;
    logic signed [64:0] r_acc;
    logic [32:0]        r_d;
    logic [31:0]        r_r;
    logic signed [31:0] r_c;
    logic signed [31:0] r_s;
    logic signed [32:0] r_t;
    logic signed [31:0] r_tmp;
    logic [3:0]         r_step;

    t_iu_ctl     iu_ctl;
    t_iu_sts     iu_sts;
    logic [63:0] iu_num;
    logic [32:0] iu_den;
    logic [63:0] iu_res;

    logic [31:0]        n_m0, n_m1, n_m2;
    logic [1:0]         n_q;
    logic               n_tie_hit;
    logic signed [31:0] n_p;
    logic signed [32:0] n_diff;
    logic [32:0]        n_adiff;
    logic [1:0]         k_idx, l_idx, o1_idx, o2_idx;
    logic [30:0]        n_ds, n_ps;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [1:0]         rot_j, rot_ph;
    logic [3:0]         row_base;
    logic signed [31:0] x1, x2;
    logic signed [64:0] n_mac;
    logic signed [31:0] n_sat;

    // Plane indexes for the current pivot pair
    always_comb begin
        unique case (r_q)
            2'd0:    begin k_idx = 2'd0; l_idx = 2'd1; o1_idx = 2'd1; o2_idx = 2'd2; end
            2'd1:    begin k_idx = 2'd0; l_idx = 2'd2; o1_idx = 2'd0; o2_idx = 2'd2; end
            default: begin k_idx = 2'd1; l_idx = 2'd2; o1_idx = 2'd0; o2_idx = 2'd1; end
        endcase
    end

    // Find the pivot: largest magnitude, rotating choice on a tie
    always_comb begin
        n_m0 = r_off[0][31] ? 32'(-r_off[0]) : 32'(r_off[0]);
        n_m1 = r_off[1][31] ? 32'(-r_off[1]) : 32'(r_off[1]);
        n_m2 = r_off[2][31] ? 32'(-r_off[2]) : 32'(r_off[2]);
        n_tie_hit = 1'b0;
        priority if (n_m0 > n_m1 && n_m0 > n_m2) n_q = 2'd0;
        else if (n_m1 > n_m0 && n_m1 > n_m2)      n_q = 2'd1;
        else if (n_m2 > n_m0 && n_m2 > n_m1)      n_q = 2'd2;
        else begin
            n_q       = r_tie;
            n_tie_hit = 1'b1;
        end
        n_p = r_off[n_q];
        unique case (n_q)
            2'd0:    n_diff = 33'(r_diag[1]) - 33'(r_diag[0]);
            2'd1:    n_diff = 33'(r_diag[2]) - 33'(r_diag[0]);
            default: n_diff = 33'(r_diag[2]) - 33'(r_diag[1]);
        endcase
        n_adiff = n_diff[32] ? 33'(-n_diff) : 33'(n_diff);
    end

    // Scale |p| and d below 2^31 together
    always_comb begin
        priority if (r_d[32]) begin
            n_ds = r_d[32:2];
            n_ps = 31'(r_pa >> 2);
        end else if (r_d[31]) begin
            n_ds = r_d[31:1];
            n_ps = 31'(r_pa >> 1);
        end else begin
            n_ds = r_d[30:0];
            n_ps = r_pa[30:0];
        end
    end

    // Select rotation operands for the current step
    always_comb begin
        rot_j    = r_step[3:2];
        rot_ph   = r_step[1:0];
        row_base = (rot_j == 2'd1) ? 4'd0 : ((rot_j == 2'd2) ? 4'd3 : 4'd6);
        if (rot_j == 2'd0) begin
            x1 = r_off[o1_idx];
            x2 = r_off[o2_idx];
        end else begin
            x1 = r_vec[row_base + 4'(k_idx)];
            x2 = r_vec[row_base + 4'(l_idx)];
        end
    end

    // Drive the shared multiplier
    always_comb begin
        unique case (r_state)
            ST_M1:   begin mul_a = {1'b0, r_pa}; mul_b = {1'b0, r_pa}; end
            ST_M2:   begin mul_a = {1'b0, r_ay}; mul_b = {1'b0, r_ay}; end
            ST_M3:   begin mul_a = {2'b00, n_ps}; mul_b = {2'b00, n_ps}; end
            ST_M4:   begin mul_a = {2'b00, n_ds}; mul_b = {2'b00, n_ds}; end
            ST_ROT: begin
                mul_a = (rot_ph == 2'd0 || rot_ph == 2'd3) ? 33'(r_c) : 33'(r_s);
                mul_b = (rot_ph == 2'd0 || rot_ph == 2'd2) ? 33'(x1) : 33'(x2);
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
        n_mac = (rot_ph == 2'd1) ? (r_acc - mul_p[64:0]) : (r_acc + mul_p[64:0]);
        n_sat = sat_to(rnd30(n_mac), (rot_j == 2'd0) ? VW_EFF : 32);
    end

    // Drive the iterative unit
    always_comb begin
        iu_ctl.start = (r_state == ST_SQ1S) || (r_state == ST_SQ2S) ||
                       (r_state == ST_DV1S) || (r_state == ST_DV2S) ||
                       (r_state == ST_DV3S);
        iu_ctl.mode  = (r_state == ST_SQ1S || r_state == ST_SQ2S) ? IU_SQRT : IU_DIV;
        unique case (r_state)
            ST_DV1S: begin iu_num = {3'b000, n_ds, 30'd0}; iu_den = {1'b0, r_r}; end
            ST_DV2S: begin iu_num = {3'b000, n_ps, 30'd0}; iu_den = {1'b0, r_r}; end
            ST_DV3S: begin iu_num = r_pp;                  iu_den = r_d;         end
            default: begin iu_num = r_acc[63:0];           iu_den = r_d;         end
        endcase
    end

    jse_iter_unit u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (iu_ctl),
        .i_num    (iu_num),
        .i_den    (iu_den),
        .o_sts    (iu_sts),
        .o_result (iu_res)
    );

    // Sequence input, rotations and result items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_max   <= MAX_ROT_RESET;
            r_oidx  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_diag[0] <= sat_to(36'(i_a00), VW_EFF);
                        r_off[0]  <= sat_to(36'(i_a01), VW_EFF);
                        r_off[1]  <= sat_to(36'(i_a02), VW_EFF);
                        r_diag[1] <= sat_to(36'(i_a11), VW_EFF);
                        r_off[2]  <= sat_to(36'(i_a12), VW_EFF);
                        r_diag[2] <= sat_to(36'(i_a22), VW_EFF);
                        for (int i = 0; i < 9; i++) begin
                            r_vec[i] <= (i % 4 == 0) ? Q30_ONE : 32'sd0;
                        end
                        r_chg   <= 3'b111;
                        r_tie   <= 2'd0;
                        r_cnt   <= 8'd0;
                        r_oidx  <= 2'd0;
                        r_state <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    if (r_chg == 3'b000) begin
                        r_lim   <= 1'b0;
                        r_state <= ST_OUT;
                    end else begin
                        if (n_tie_hit) begin
                            r_tie <= (r_tie == 2'd2) ? 2'd0 : r_tie + 2'd1;
                        end
                        if (n_p == 32'sd0) begin
                            r_lim   <= 1'b0;
                            r_state <= ST_OUT;
                        end else if (r_cnt >= r_max) begin
                            r_lim   <= 1'b1;
                            r_state <= ST_OUT;
                        end else begin
                            r_q     <= n_q;
                            r_p     <= n_p;
                            r_pa    <= n_p[31] ? 32'(-n_p) : 32'(n_p);
                            r_ay    <= n_adiff[32:1];
                            r_neg   <= n_diff[32];
                            r_state <= ST_M1;
                        end
                    end
                end
                ST_M1: begin
                    r_pp    <= mul_p[63:0];
                    r_state <= ST_M2;
                end
                ST_M2: begin
                    r_acc   <= {1'b0, r_pp} + mul_p[64:0];
                    r_state <= ST_SQ1S;
                end
                ST_SQ1S: r_state <= ST_SQ1W;
                ST_SQ1W: begin
                    if (iu_sts.done) begin
                        r_d     <= {1'b0, r_ay} + {1'b0, iu_res[31:0]};
                        r_state <= ST_M3;
                    end
                end
                ST_M3: begin
                    r_acc   <= mul_p[64:0];
                    r_state <= ST_M4;
                end
                ST_M4: begin
                    r_acc   <= r_acc + mul_p[64:0];
                    r_state <= ST_SQ2S;
                end
                ST_SQ2S: r_state <= ST_SQ2W;
                ST_SQ2W: begin
                    if (iu_sts.done) begin
                        r_r     <= iu_res[31:0];
                        r_state <= ST_DV1S;
                    end
                end
                ST_DV1S: r_state <= ST_DV1W;
                ST_DV1W: begin
                    if (iu_sts.done) begin
                        r_c     <= iu_res[31:0];
                        r_state <= ST_DV2S;
                    end
                end
                ST_DV2S: r_state <= ST_DV2W;
                ST_DV2W: begin
                    if (iu_sts.done) begin
                        r_s     <= (r_p[31] ^ r_neg) ? -$signed(iu_res[31:0])
                                                      : $signed(iu_res[31:0]);
                        r_state <= ST_DV3S;
                    end
                end
                ST_DV3S: r_state <= ST_DV3W;
                ST_DV3W: begin
                    if (iu_sts.done) begin
                        r_t     <= r_neg ? -$signed({1'b0, iu_res[31:0]})
                                         : $signed({1'b0, iu_res[31:0]});
                        r_state <= ST_DIAG;
                    end
                end
                ST_DIAG: begin
                    logic signed [31:0] nk;
                    logic signed [31:0] nl;
                    nk = sat_to(36'(r_diag[k_idx]) - 36'(r_t), VW_EFF);
                    nl = sat_to(36'(r_diag[l_idx]) + 36'(r_t), VW_EFF);
                    r_diag[k_idx] <= nk;
                    r_diag[l_idx] <= nl;
                    r_chg[k_idx]  <= (nk != r_diag[k_idx]);
                    r_chg[l_idx]  <= (nl != r_diag[l_idx]);
                    r_off[r_q]    <= 32'sd0;
                    r_step        <= 4'd0;
                    r_state       <= ST_ROT;
                end
                ST_ROT: begin
                    unique case (rot_ph)
                        2'd0, 2'd2: r_acc <= mul_p[64:0];
                        2'd1:       r_tmp <= n_sat;
                        default: begin
                            if (rot_j == 2'd0) begin
                                r_off[o1_idx] <= r_tmp;
                                r_off[o2_idx] <= n_sat;
                            end else begin
                                r_vec[row_base + 4'(k_idx)] <= r_tmp;
                                r_vec[row_base + 4'(l_idx)] <= n_sat;
                            end
                        end
                    endcase
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd15) begin
                        r_cnt   <= r_cnt + 8'd1;
                        r_state <= ST_PICK;
                    end
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        if (r_oidx == 2'd2) begin
                            r_oidx  <= 2'd0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 2'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Present result items from the finished state
    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = (r_state == ST_OUT);
    assign o_eigen_value   = r_diag[r_oidx];
    assign o_vec_x         = r_vec[4'(r_oidx)];
    assign o_vec_y         = r_vec[4'(r_oidx) + 4'd3];
    assign o_vec_z         = r_vec[4'(r_oidx) + 4'd6];
    assign o_pair_index    = r_oidx;
    assign o_last_pair     = (r_oidx == 2'd2);
    assign o_limit_reached = r_lim;

    // Result index stays within the three eigenpairs
    a_oidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_oidx != 2'd3))
        else $error("result index out of range");

    // Rotation count never passes the limit while an item is in work
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_cnt <= r_max))
        else $error("rotation count exceeds limit");

    // Iterative unit completes only while the sequencer waits for it
    a_iu_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iu_sts.done |-> (r_state == ST_SQ1W || r_state == ST_SQ2W ||
                         r_state == ST_DV1W || r_state == ST_DV2W ||
                         r_state == ST_DV3W))
        else $error("iterative unit done outside a wait state");

    // Iterative unit is never started while busy
    a_iu_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iu_ctl.start |-> !iu_sts.busy)
        else $error("iterative unit started while busy");

    // Pivot entry stays cleared through the plane rotation
    a_pivot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROT) |-> (r_off[r_q] == 32'sd0))
        else $error("pivot not cleared during rotation");

endmodule

### rtl/core/jse_iter_unit.sv
// Shared iterative unit: 64-bit floor square root or 64/33-bit unsigned division.
module jse_iter_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jse_pkg::t_iu_ctl i_ctl,
    input  logic [63:0]      i_num,
    input  logic [32:0]      i_den,
    output jse_pkg::t_iu_sts o_sts,
    output logic [63:0]      o_result
);
    import jse_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic        r_mode;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [32:0] r_den;

    logic [34:0] n_sq_sh;
    logic [34:0] n_sq_try;
    logic [34:0] n_dv_sh;
    logic [5:0]  n_last;

    // Form one step of either operation
    always_comb begin
        n_sq_sh  = {r_rem[32:0], r_q[63:62]};
        n_sq_try = {1'b0, r_root, 2'b01};
        n_dv_sh  = {1'b0, r_rem[32:0], r_q[63]};
        n_last   = (r_mode == IU_SQRT) ? 6'd31 : 6'd63;
    end

    // Start, iterate one digit per cycle, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_mode <= i_ctl.mode;
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_mode == IU_SQRT) begin
                    r_q <= {r_q[61:0], 2'b00};
                    if (n_sq_sh >= n_sq_try) begin
                        r_rem  <= n_sq_sh - n_sq_try;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= n_sq_sh;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                end else begin
                    if (n_dv_sh >= {2'b00, r_den}) begin
                        r_rem <= n_dv_sh - {2'b00, r_den};
                        r_q   <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= n_dv_sh;
                        r_q   <= {r_q[62:0], 1'b0};
                    end
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == n_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_result   = (r_mode == IU_SQRT) ? {32'd0, r_root} : r_q;

endmodule

### dv/jacobi_symmetric_eigen_3x3_core_test.sv
// Self-checking testbench for the 3x3 symmetric Jacobi eigen core.
module jacobi_symmetric_eigen_3x3_core_test;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        t_word a00;
        t_word a01;
        t_word a02;
        t_word a11;
        t_word a12;
        t_word a22;
    } t_matrix;

    typedef struct packed {
        t_word      eigen_value;
        t_word      vec_x;
        t_word      vec_y;
        t_word      vec_z;
        logic [1:0] pair_index;
        logic       last_pair;
        logic       limit_reached;
    } t_eigenpair;

    typedef struct packed {
        t_matrix m;
        logic    typed;
    } t_row;

    localparam t_word MAXV = 32'sh7fff_ffff;
    localparam t_word MINV = 32'sh8000_0000;
    localparam t_word ONE  = 32'sh0001_0000;
    localparam t_word Q30  = 32'sh4000_0000;
    localparam int    IDLE_LIMIT = 400000;
    localparam int    NUM_ROWS = 16;

    // Stimulus table; typed rows have no off-diagonal entry, so results read off directly
    localparam t_row DIR_ROWS [NUM_ROWS] = '{
        '{'{0, 0, 0, 0, 0, 0}, 1'b1},
        '{'{MAXV, 0, 0, MINV, 0, MAXV}, 1'b1},
        '{'{ONE, 0, 0, ONE, 0, ONE}, 1'b1},
        '{'{MINV, 0, 0, -1, 0, 1}, 1'b1},
        '{'{2 * ONE, ONE, 0, 2 * ONE, 0, 3 * ONE}, 1'b0},
        '{'{ONE, 0, 2 * ONE, -ONE, 0, 4 * ONE}, 1'b0},
        '{'{0, 0, 0, ONE, -3 * ONE, 5 * ONE}, 1'b0},
        '{'{ONE, ONE, ONE, ONE, ONE, ONE}, 1'b0},
        '{'{3 * ONE, -ONE, ONE, 0, -ONE, 2 * ONE}, 1'b0},
        '{'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 1'b0},
        '{'{MINV, MINV, MINV, MINV, MINV, MINV}, 1'b0},
        '{'{MAXV, MINV, 0, MINV, MAXV, MAXV}, 1'b0},
        '{'{5 * ONE, ONE, 0, ONE, 0, 0}, 1'b0},
        '{'{0, ONE, 2 * ONE, 0, 2 * ONE, 0}, 1'b0},
        '{'{-7, 3, -2, 11, 5, -1}, 1'b0},
        '{'{32'sh1234_5678, 32'sh0abc_def0, -32'sh0123_4567, 32'sh7654_3210,
            32'sh00fe_dcba, -32'sh4000_0000}, 1'b0}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_word      i_a00, i_a01, i_a02, i_a11, i_a12, i_a22;
    logic       o_out_valid;
    logic       i_out_stall;
    t_word      o_eigen_value, o_vec_x, o_vec_y, o_vec_z;
    logic [1:0] o_pair_index;
    logic       o_last_pair;
    logic       o_limit_reached;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    t_eigenpair pending_pairs[$];
    logic [7:0] rotation_limit;
    int         mismatches;
    int         idle_cycles;
    int         out_gap;
    bit         in_burst;
    bit         out_burst;

    jacobi_symmetric_eigen_3x3_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_a00(i_a00), .i_a01(i_a01), .i_a02(i_a02),
        .i_a11(i_a11), .i_a12(i_a12), .i_a22(i_a22),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_eigen_value(o_eigen_value), .o_vec_x(o_vec_x), .o_vec_y(o_vec_y),
        .o_vec_z(o_vec_z), .o_pair_index(o_pair_index), .o_last_pair(o_last_pair),
        .o_limit_reached(o_limit_reached),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Clock: period 4
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint sat32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // (a*b - e*f) rounded half up at bit 30
    function automatic longint rotate_q30(input longint a, input longint b,
                                          input longint e, input longint f);
        return (a * b - e * f + 64'sd536870912) >>> 30;
    endfunction

    // Run the rotations on one matrix and queue its three eigenpairs
    function automatic void predict_eigenpairs(input t_matrix m);
        longint          offd[3];
        longint          diag[3];
        longint          vecs[9];
        bit              changed[3];
        int              tie;
        int              count;
        bit              limited;
        longint          mag[3];
        int              q, k, l, o1, o2;
        longint          p, diff, y, c, smag, s, t, x1, x2, ek, el, old;
        longint unsigned ay, pa, d, ds, ps, r;
        bit              neg;
        t_eigenpair      res;
        diag = '{m.a00, m.a11, m.a22};
        offd = '{m.a01, m.a02, m.a12};
        for (int i = 0; i < 9; i++) vecs[i] = (i % 4 == 0) ? 64'sd1073741824 : 0;
        changed = '{1, 1, 1};
        tie = 0;
        count = 0;
        limited = 0;
        while (changed[0] || changed[1] || changed[2]) begin
            for (int i = 0; i < 3; i++) mag[i] = offd[i] < 0 ? -offd[i] : offd[i];
            if (mag[0] > mag[1] && mag[0] > mag[2]) q = 0;
            else if (mag[1] > mag[0] && mag[1] > mag[2]) q = 1;
            else if (mag[2] > mag[0] && mag[2] > mag[1]) q = 2;
            else begin
                q = tie;
                tie = (tie + 1) % 3;
            end
            case (q)
                0: begin k = 0; l = 1; o1 = 1; o2 = 2; end
                1: begin k = 0; l = 2; o1 = 0; o2 = 2; end
                default: begin k = 1; l = 2; o1 = 0; o2 = 1; end
            endcase
            p = offd[q];
            if (p == 0) break;
            if (count >= rotation_limit) begin
                limited = 1;
                break;
            end
            diff = diag[l] - diag[k];
            y = diff / 2;
            ay = y < 0 ? -y : y;
            pa = p < 0 ? -p : p;
            d = ay + floor_sqrt(pa * pa + ay * ay);
            ds = d;
            ps = pa;
            while (ds >= 64'd2147483648) begin
                ds >>= 1;
                ps >>= 1;
            end
            r = floor_sqrt(ps * ps + ds * ds);
            c = (ds << 30) / r;
            smag = (ps << 30) / r;
            t = (pa * pa) / d;
            neg = diff < 0;
            s = ((p < 0) != neg) ? -smag : smag;
            if (neg) t = -t;
            offd[q] = 0;
            old = diag[k];
            diag[k] = sat32(old - t);
            changed[k] = diag[k] != old;
            old = diag[l];
            diag[l] = sat32(old + t);
            changed[l] = diag[l] != old;
            x1 = offd[o1];
            x2 = offd[o2];
            offd[o1] = sat32(rotate_q30(c, x1, s, x2));
            offd[o2] = sat32(rotate_q30(s, x1, -c, x2));
            for (int i = 0; i < 3; i++) begin
                ek = vecs[i * 3 + k];
                el = vecs[i * 3 + l];
                vecs[i * 3 + k] = sat32(rotate_q30(c, ek, s, el));
                vecs[i * 3 + l] = sat32(rotate_q30(s, ek, -c, el));
            end
            count++;
        end
        for (int i = 0; i < 3; i++) begin
            res.eigen_value   = diag[i][31:0];
            res.vec_x         = vecs[i][31:0];
            res.vec_y         = vecs[3 + i][31:0];
            res.vec_z         = vecs[6 + i][31:0];
            res.pair_index    = i[1:0];
            res.last_pair     = (i == 2);
            res.limit_reached = limited;
            pending_pairs.push_back(res);
        end
    endfunction

    // Draw one random matrix; half are well-formed moderate values
    function automatic t_matrix random_matrix();
        t_matrix m;
        t_word   picks[5];
        t_word   w;
        int      kind;
        picks = '{MAXV, MINV, 0, 1, -1};
        kind = $urandom_range(0, 9);
        m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind <= 4) begin
            m.a00 = $signed($urandom) >>> $urandom_range(4, 16);
            m.a01 = $signed($urandom) >>> $urandom_range(4, 16);
            m.a02 = $signed($urandom) >>> $urandom_range(4, 16);
            m.a11 = $signed($urandom) >>> $urandom_range(4, 16);
            m.a12 = $signed($urandom) >>> $urandom_range(4, 16);
            m.a22 = $signed($urandom) >>> $urandom_range(4, 16);
        end else if (kind == 5) begin
            w = $urandom_range(0, 1 << 20);
            m.a01 = $urandom_range(0, 1) ? w : -w;
            m.a02 = $urandom_range(0, 1) ? w : -w;
            m.a12 = $urandom_range(0, 1) ? w : -w;
        end else if (kind == 6) begin
            m.a01 = 0;
            m.a02 = 0;
            m.a12 = 0;
        end else if (kind == 7) begin
            m.a00 = picks[$urandom_range(0, 4)];
            m.a01 = picks[$urandom_range(0, 4)];
            m.a02 = picks[$urandom_range(0, 4)];
            m.a11 = picks[$urandom_range(0, 4)];
            m.a12 = picks[$urandom_range(0, 4)];
            m.a22 = picks[$urandom_range(0, 4)];
        end
        return m;
    endfunction

    // Offer one matrix and hold it until taken
    task automatic send_matrix(input t_matrix m);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        {i_a00, i_a01, i_a02, i_a11, i_a12, i_a22} <= m;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    endtask

    // Drain all results, then write the rotation limit
    task automatic write_limit(input logic [7:0] value);
        i_in_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        rotation_limit = value;
    endtask

    task automatic random_phase(input logic [7:0] limit, input int count);
        write_limit(limit);
        for (int n = 0; n < count; n++) begin
            t_matrix m;
            m = random_matrix();
            send_matrix(m);
            predict_eigenpairs(m);
        end
    endtask

    // Check each result against the oldest expected eigenpair; draw output stalls
    always @(posedge i_clk) begin
        t_eigenpair got;
        t_eigenpair want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_eigen_value, o_vec_x, o_vec_y, o_vec_z,
                        o_pair_index, o_last_pair, o_limit_reached};
                if (pending_pairs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: %p", got);
                end else begin
                    want = pending_pairs.pop_front();
                    if (got.eigen_value !== want.eigen_value || got.vec_x !== want.vec_x ||
                        got.vec_y !== want.vec_y || got.vec_z !== want.vec_z ||
                        got.pair_index !== want.pair_index ||
                        got.last_pair !== want.last_pair ||
                        got.limit_reached !== want.limit_reached) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
                if ($urandom_range(0, 40) == 0) out_burst = !out_burst;
                out_gap = out_burst ? 0 : $urandom_range(0, 7);
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("jacobi_symmetric_eigen_3x3_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        t_eigenpair typed_pair;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 8'd0;
        {i_a00, i_a01, i_a02, i_a11, i_a12, i_a22} = '0;
        mismatches     = 0;
        idle_cycles    = 0;
        out_gap        = 0;
        in_burst       = 0;
        out_burst      = 0;
        rotation_limit = 8'd64;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset limit
        for (int n = 0; n < NUM_ROWS; n++) begin
            send_matrix(DIR_ROWS[n].m);
            if (DIR_ROWS[n].typed) begin
                typed_pair = '{DIR_ROWS[n].m.a00, Q30, 0, 0, 2'd0, 1'b0, 1'b0};
                pending_pairs.push_back(typed_pair);
                typed_pair = '{DIR_ROWS[n].m.a11, 0, Q30, 0, 2'd1, 1'b0, 1'b0};
                pending_pairs.push_back(typed_pair);
                typed_pair = '{DIR_ROWS[n].m.a22, 0, 0, Q30, 2'd2, 1'b1, 1'b0};
                pending_pairs.push_back(typed_pair);
            end else begin
                predict_eigenpairs(DIR_ROWS[n].m);
            end
        end

        // Random phases across limit settings, extremes included
        random_phase(8'd0, 20);
        random_phase(8'd1, 100);
        random_phase(8'd255, 6);
        random_phase(8'd3, 150);
        random_phase(8'd16, 150);
        random_phase(8'd64, 24);

        i_in_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_pairs.size() == 0) begin
            $display("jacobi_symmetric_eigen_3x3_core regression: pass");
        end else begin
            $display("jacobi_symmetric_eigen_3x3_core regression: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/jse_pkg.sv
rtl/core/jse_iter_unit.sv
rtl/core/jacobi_symmetric_eigen_3x3_core.sv
dv/jacobi_symmetric_eigen_3x3_core_test.sv
